/* hdl/ltsb_pkg.sv */
// Package: shared types, constants and functions of the looping timer slot bank.
`timescale 1ns / 1ps
package ltsb_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam logic [15:0] SEED_RESET = 16'hACE1;
   localparam logic [15:0] FOREVER = 16'hFFFF;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam logic [6:0] DRAW_MOD = 7'd100;

   typedef enum logic [1:0] {
      MODE_START   = 2'd0,
      MODE_SET     = 2'd1,
      MODE_ADVANCE = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_STARTED  = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_FINISHED = 3'd2,
      KIND_VALUE    = 3'd3,
      KIND_ACK      = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_PLAY  = 2'd1,
      ST_PAUSE = 2'd2,
      ST_DONE  = 2'd3
   } slot_state_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_START,
      FSM_SET,
      FSM_READ,
      FSM_ADV_RD,
      FSM_ADV_CALC,
      FSM_ADV_WR,
      FSM_FIN_RD,
      FSM_FIN_CHK,
      FSM_EMIT,
      FSM_DONE,
      FSM_WAIT
   } fsm_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  slot;
      logic [1:0]  new_state;
      logic [15:0] elapsed;
      logic [15:0] duration;
      logic [15:0] loop_count;
      logic [31:0] finish_tag;
      logic signed [15:0] range_start;
      logic signed [15:0] range_end;
      logic [6:0]  chance;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  result_slot;
      logic [31:0] done_tag;
      logic signed [15:0] current_value;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch request
      logic do_start;   // allocate head slot
      logic do_set;     // apply set state
      logic read_req;   // read value of request slot
      logic scan_clear; // clear scan index
      logic scan_inc;   // next scan slot
      logic scan_rd;    // read slot at scan index
      logic adv_calc;   // compute advance of scan slot
      logic adv_wr;     // write back advance result
      logic do_free;    // free scan slot
      logic seed_wr;    // load seed
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       scan_end;
      logic       is_play;
      logic       is_done;
      logic       tag_nz;
   } stat_type;

   // Quotient estimate never exceeds the true one and is at most one short.
   function automatic logic [6:0] mod100(input logic [15:0] v);
      logic [31:0] q;
      logic [15:0] r;
      begin
         q = (32'(v) * 32'd655) >> 16;
         r = v - 16'(q[15:0] * 16'd100);
         if (r >= 16'd100) r = r - 16'd100;
         mod100 = r[6:0];
      end
   endfunction

endpackage

/* hdl/ltsb_stream_if.sv */
// Interface: valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
interface ltsb_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/looping_timer_slot_bank.sv */
// Top level: looping timer slot bank with request, result and seed channels.
//
// Usage:
//  req  : one beat per item (mode start, set state, advance, read).
//  rsp  : one or more beats per item; last marks the final beat.
//         Start, set state and read give one beat; advance gives one
//         finished beat per finished slot with a nonzero tag, ascending,
//         then an advance-done beat.
//  csr  : seed write; loads the LFSR, except in a cycle where an advance step updates it. Always ready.
// Sequence: start and set state are handled in the dispatch state; read takes a
//   further read state; advance steps the scan through every slot twice, first
//   advancing playing slots, then emitting and freeing finished ones.
// Throughput: one item at a time; req_ready is high only when idle.
// Reset: all slots free, free list in slot order, LFSR holds the default
//   seed. No clearing pass.
// Stall: a result beat is held in the output register until taken; the
//   scan waits while a finished beat is pending.
`timescale 1ns / 1ps
module looping_timer_slot_bank #(
   parameter int SLOTS = ltsb_pkg::SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   ltsb_stream_if.sink   req,
   ltsb_stream_if.source rsp,
   ltsb_stream_if.sink   csr
);
   ltsb_pkg::cmd_type  cmd;
   ltsb_pkg::stat_type stat;
   ltsb_pkg::rsp_type  rsp_word;

   ltsb_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .csr_valid (csr.valid),
      .csr_ready (csr.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_data  (rsp.data),
      .rsp_word  (rsp_word),
      .stat      (stat),
      .cmd       (cmd)
   );

   ltsb_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req.data),
      .seed     (csr.data),
      .stat     (stat),
      .rsp_word (rsp_word)
   );
endmodule

/* hdl/ltsb_datapath.sv */
// Datapath: slot tables, free list, LFSR and result word.
`timescale 1ns / 1ps
module ltsb_datapath #(
   parameter int SLOTS = ltsb_pkg::SLOTS_DEFAULT,
   localparam int IW = $clog2(SLOTS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  ltsb_pkg::cmd_type  cmd,
   input  ltsb_pkg::req_type  req_data,
   input  logic [15:0]        seed,
   output ltsb_pkg::stat_type stat,
   output ltsb_pkg::rsp_type  rsp_word
);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   ltsb_pkg::req_type req_ff;
   logic [1:0]  status_ff [SLOTS];
   logic [1:0]  status_in [SLOTS];
   logic [IW-1:0] next_free_ff [SLOTS];
   logic [IW-1:0] head_ff, head_in;
   logic [15:0] lfsr_ff, lfsr_in;
   logic [IW-1:0] scan_ff, scan_in;

   logic [15:0] loops_mem [SLOTS];
   logic [15:0] period_mem [SLOTS];
   logic [31:0] time_mem [SLOTS];
   logic [31:0] tag_mem [SLOTS];
   logic signed [15:0] low_mem [SLOTS];
   logic signed [15:0] high_mem [SLOTS];
   logic signed [15:0] now_mem [SLOTS];
   logic [6:0]  chance_mem [SLOTS];

   logic [15:0] rd_loops_ff, rd_period_ff, new_loops_ff;
   logic [31:0] rd_time_ff, rd_tag_ff, new_time_ff;
   logic signed [15:0] rd_low_ff, rd_high_ff, rd_now_ff, new_now_ff, read_val_ff;
   logic [6:0]  rd_chance_ff;
   logic        new_done_ff;

   logic [AW-1:0] head_idx, scan_idx, req_idx;
   logic          req_ok;
   logic [32:0]   sum;
   logic [31:0]   t_sat;
   logic [15:0]   lfsr_step;
   logic signed [16:0] nv;
   logic [15:0]   adv_loops;
   logic [31:0]   adv_time;
   logic          adv_done;
   logic signed [15:0] adv_now;

   assign head_idx = head_ff[AW-1:0];
   assign scan_idx = scan_ff[AW-1:0];
   assign req_idx  = AW'(req_ff.slot);
   assign req_ok   = 32'(req_ff.slot) < SLOTS;

   assign lfsr_step = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ ltsb_pkg::LFSR_TAPS) : (lfsr_ff >> 1);
   assign sum   = 33'(rd_time_ff) + 33'(req_ff.elapsed);
   assign t_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign nv    = 17'(rd_now_ff) + 17'sd1;

   always_comb begin
      adv_loops = rd_loops_ff;
      adv_time  = t_sat;
      adv_done  = 1'b0;
      if (t_sat >= 32'(rd_period_ff)) begin
         if (rd_loops_ff == ltsb_pkg::FOREVER) begin
            adv_time = t_sat - 32'(rd_period_ff);
         end else begin
            adv_loops = rd_loops_ff - 16'd1;
            if (rd_loops_ff != 16'd1) adv_time = t_sat - 32'(rd_period_ff);
            else adv_done = 1'b1;
         end
      end
      adv_now = rd_now_ff;
      if (rd_chance_ff < ltsb_pkg::mod100(lfsr_step))
         adv_now = (nv < 17'(rd_high_ff)) ? nv[15:0] : rd_low_ff;
   end

   always_comb begin
      head_in = head_ff;
      lfsr_in = lfsr_ff;
      scan_in = scan_ff;
      for (int i = 0; i < SLOTS; i++) status_in[i] = status_ff[i];
      if (cmd.seed_wr) lfsr_in = seed;
      if (cmd.do_start && head_ff < IW'(SLOTS)) begin
         head_in = next_free_ff[head_idx];
         status_in[head_idx] = ltsb_pkg::ST_PLAY;
      end
      if (cmd.do_set && req_ok && status_ff[req_idx] != ltsb_pkg::ST_FREE) begin
         if (req_ff.new_state == ltsb_pkg::ST_FREE) begin
            status_in[req_idx] = ltsb_pkg::ST_FREE;
            head_in = IW'(req_idx);
         end else if (req_ff.new_state == ltsb_pkg::ST_PLAY ||
                      req_ff.new_state == ltsb_pkg::ST_PAUSE) begin
            status_in[req_idx] = req_ff.new_state;
         end
      end
      if (cmd.adv_calc) lfsr_in = lfsr_step;
      if (cmd.adv_wr && new_done_ff) status_in[scan_idx] = ltsb_pkg::ST_DONE;
      if (cmd.do_free) begin
         status_in[scan_idx] = ltsb_pkg::ST_FREE;
         head_in = scan_ff;
      end
      if (cmd.scan_clear) scan_in = '0;
      else if (cmd.scan_inc) scan_in = scan_ff + IW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         lfsr_ff <= ltsb_pkg::SEED_RESET;
         scan_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            status_ff[i]    <= ltsb_pkg::ST_FREE;
            next_free_ff[i] <= IW'(i + 1);
         end
      end else begin
         head_ff <= head_in;
         lfsr_ff <= lfsr_in;
         scan_ff <= scan_in;
         for (int i = 0; i < SLOTS; i++) status_ff[i] <= status_in[i];
         if (cmd.do_set && req_ok && status_ff[req_idx] != ltsb_pkg::ST_FREE &&
             req_ff.new_state == ltsb_pkg::ST_FREE)
            next_free_ff[req_idx] <= head_ff;
         if (cmd.do_free) next_free_ff[scan_idx] <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.do_start && head_ff < IW'(SLOTS)) begin
         period_mem[head_idx] <= req_ff.duration;
         loops_mem[head_idx]  <= req_ff.loop_count;
         tag_mem[head_idx]    <= req_ff.finish_tag;
         time_mem[head_idx]   <= '0;
         low_mem[head_idx]    <= req_ff.range_start;
         high_mem[head_idx]   <= req_ff.range_end;
         now_mem[head_idx]    <= req_ff.range_start;
         chance_mem[head_idx] <= req_ff.chance;
      end
      if (cmd.read_req) read_val_ff <= req_ok ? now_mem[req_idx] : '0;
      if (cmd.scan_rd) begin
         rd_loops_ff  <= loops_mem[scan_idx];
         rd_period_ff <= period_mem[scan_idx];
         rd_time_ff   <= time_mem[scan_idx];
         rd_tag_ff    <= tag_mem[scan_idx];
         rd_low_ff    <= low_mem[scan_idx];
         rd_high_ff   <= high_mem[scan_idx];
         rd_now_ff    <= now_mem[scan_idx];
         rd_chance_ff <= chance_mem[scan_idx];
      end
      if (cmd.adv_calc) begin
         new_loops_ff <= adv_loops;
         new_time_ff  <= adv_time;
         new_done_ff  <= adv_done;
         new_now_ff   <= adv_now;
      end
      if (cmd.adv_wr) begin
         loops_mem[scan_idx] <= new_loops_ff;
         time_mem[scan_idx]  <= new_time_ff;
         now_mem[scan_idx]   <= new_now_ff;
      end
   end

   always_comb begin
      stat.mode     = req_ff.mode;
      stat.full     = head_ff >= IW'(SLOTS);
      stat.scan_end = scan_ff >= IW'(SLOTS);
      stat.is_play  = !stat.scan_end && status_ff[scan_idx] == ltsb_pkg::ST_PLAY;
      stat.is_done  = !stat.scan_end && status_ff[scan_idx] == ltsb_pkg::ST_DONE;
      stat.tag_nz   = rd_tag_ff != '0;
   end

   // Result word for the controller's output register.
   always_comb begin
      rsp_word = '0;
      case (req_ff.mode)
         ltsb_pkg::MODE_START: begin
            rsp_word.kind = stat.full ? ltsb_pkg::KIND_FULL : ltsb_pkg::KIND_STARTED;
            rsp_word.result_slot = stat.full ? 4'd0 : 4'(head_ff);
         end
         ltsb_pkg::MODE_SET: begin
            rsp_word.kind = ltsb_pkg::KIND_ACK;
            rsp_word.result_slot = req_ff.slot;
         end
         ltsb_pkg::MODE_READ: begin
            rsp_word.kind = ltsb_pkg::KIND_VALUE;
            rsp_word.result_slot = req_ff.slot;
            rsp_word.current_value = read_val_ff;
         end
         default: begin
            rsp_word.kind = ltsb_pkg::KIND_FINISHED;
            rsp_word.result_slot = 4'(scan_ff);
            rsp_word.done_tag = rd_tag_ff;
         end
      endcase
      rsp_word.last = 1'b1;
   end

`ifndef SYNTHESIS
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= IW'(SLOTS)) else $error("free head out of range");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= IW'(SLOTS)) else $error("scan index out of range");
   a_head_free: assert property (@(posedge clock) disable iff (reset)
      head_ff < IW'(SLOTS) && !cmd.do_free && !cmd.do_set && !cmd.do_start |=>
      $past(head_ff) >= IW'(SLOTS) || status_ff[$past(head_idx)] != ltsb_pkg::ST_PLAY ||
      $past(status_ff[head_idx]) != ltsb_pkg::ST_FREE)
      else $error("free head slot became busy without a start");
`endif
endmodule

/* hdl/ltsb_control.sv */
// Controller: sequences item handling and drives the result channel.
`timescale 1ns / 1ps
module ltsb_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               csr_valid,
   output logic               csr_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ltsb_pkg::rsp_type  rsp_data,
   input  ltsb_pkg::rsp_type  rsp_word,
   input  ltsb_pkg::stat_type stat,
   output ltsb_pkg::cmd_type  cmd
);
   ltsb_pkg::fsm_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   ltsb_pkg::rsp_type rsp_ff, rsp_in;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
   assign req_ready = state_ff == ltsb_pkg::FSM_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltsb_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.seed_wr = csr_valid;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ltsb_pkg::FSM_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ltsb_pkg::FSM_START;
            end
         end
         ltsb_pkg::FSM_START: begin
            // Dispatch on the latched mode.
            if (!rsp_valid_in) begin
               rsp_in = rsp_word;
               case (stat.mode)
                  ltsb_pkg::MODE_START: begin
                     rsp_valid_in = 1'b1;
                     cmd.do_start = 1'b1;
                     state_in = ltsb_pkg::FSM_IDLE;
                  end
                  ltsb_pkg::MODE_SET: begin
                     rsp_valid_in = 1'b1;
                     cmd.do_set = 1'b1;
                     state_in = ltsb_pkg::FSM_IDLE;
                  end
                  ltsb_pkg::MODE_READ: begin
                     cmd.read_req = 1'b1;
                     state_in = ltsb_pkg::FSM_READ;
                  end
                  default: begin
                     cmd.scan_clear = 1'b1;
                     state_in = ltsb_pkg::FSM_ADV_RD;
                  end
               endcase
            end
         end
         ltsb_pkg::FSM_READ: begin
            rsp_in = rsp_word;
            rsp_valid_in = 1'b1;
            state_in = ltsb_pkg::FSM_IDLE;
         end
         ltsb_pkg::FSM_ADV_RD: begin
            if (stat.scan_end) begin
               cmd.scan_clear = 1'b1;
               state_in = ltsb_pkg::FSM_FIN_RD;
            end else if (stat.is_play) begin
               cmd.scan_rd = 1'b1;
               state_in = ltsb_pkg::FSM_ADV_CALC;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ltsb_pkg::FSM_ADV_CALC: begin
            cmd.adv_calc = 1'b1;
            state_in = ltsb_pkg::FSM_ADV_WR;
         end
         ltsb_pkg::FSM_ADV_WR: begin
            cmd.adv_wr = 1'b1;
            cmd.scan_inc = 1'b1;
            state_in = ltsb_pkg::FSM_ADV_RD;
         end
         ltsb_pkg::FSM_FIN_RD: begin
            if (stat.scan_end) begin
               state_in = ltsb_pkg::FSM_DONE;
            end else if (stat.is_done) begin
               cmd.scan_rd = 1'b1;
               state_in = ltsb_pkg::FSM_FIN_CHK;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ltsb_pkg::FSM_FIN_CHK: begin
            if (!stat.tag_nz) begin
               cmd.do_free = 1'b1;
               cmd.scan_inc = 1'b1;
               state_in = ltsb_pkg::FSM_FIN_RD;
            end else if (!rsp_valid_in) begin
               rsp_in = rsp_word;
               rsp_in.last = 1'b0;
               rsp_valid_in = 1'b1;
               cmd.do_free = 1'b1;
               cmd.scan_inc = 1'b1;
               state_in = ltsb_pkg::FSM_FIN_RD;
            end
         end
         ltsb_pkg::FSM_DONE: begin
            if (!rsp_valid_in) begin
               rsp_in = '0;
               rsp_in.kind = ltsb_pkg::KIND_ACK;
               rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ltsb_pkg::FSM_IDLE;
            end
         end
         default: state_in = ltsb_pkg::FSM_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result beat dropped while stalled");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_start, cmd.do_set, cmd.adv_calc, cmd.do_free}))
      else $error("conflicting datapath commands");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ltsb_pkg::FSM_START)
      else $error("accepted beat not dispatched");
`endif
endmodule
